### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/otsu_pkg.sv
// ----------------------------------------------------------------------------
// Otsu threshold package
// Widths, constants and shared types of the Otsu threshold core.
// ----------------------------------------------------------------------------
package otsu_pkg;

   localparam int BIN_BITS = 16;
   localparam int LEVELS   = 256;
   localparam int LVL_W    = 8;
   localparam logic [LVL_W-1:0] TOP_LEVEL = 8'd255;
   localparam logic [BIN_BITS-1:0] BIN_MAX = {BIN_BITS{1'b1}};

   localparam int TOT_W   = BIN_BITS + LVL_W;
   localparam int SUM_W   = TOT_W + LVL_W;
   localparam int D_W     = SUM_W + TOT_W;
   localparam int NUM_W   = 2 * D_W;
   localparam int DEN_W   = 2 * TOT_W;
   localparam int CROSS_W = NUM_W + DEN_W;

   localparam int MA_W   = NUM_W;
   localparam int MB_W   = D_W;
   localparam int MP_W   = MA_W + MB_W;
   localparam int MCNT_W = $clog2(MB_W);

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

### design/otsu_mul.sv
// ----------------------------------------------------------------------------
// Otsu shift-add multiplier
// Shared multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module otsu_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [otsu_pkg::MA_W-1:0] op_a,
   input  logic [otsu_pkg::MB_W-1:0] op_b,
   output otsu_pkg::mul_stat_type    stat,
   output logic [otsu_pkg::MP_W-1:0] product
);
   import otsu_pkg::*;

   logic [MP_W-1:0]   acc_ff;
   logic [MP_W-1:0]   ash_ff;
   logic [MB_W-1:0]   bsh_ff;
   logic [MCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff  <= '0;
            ash_ff  <= MP_W'(op_a);
            bsh_ff  <= op_b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (bsh_ff[0]) begin
               acc_ff <= acc_ff + ash_ff;
            end
            ash_ff <= ash_ff << 1;
            bsh_ff <= bsh_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MCNT_W'(MB_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

### design/otsu_threshold_core.sv
// ----------------------------------------------------------------------------
// Otsu threshold core
// Histograms 8-bit pixels of a frame and returns the Otsu threshold.
// ----------------------------------------------------------------------------
// Each pixel transaction reads one histogram bin and then writes it back
// incremented with saturation. After the pixel marked last, a scan over all
// bins, with a read state and an accumulate state per bin, finds the occupied
// range and the totals; then each candidate threshold from the least level
// up to below the greatest level needs five products on the shared shift-add
// multiplier. The result is then registered and a clearing pass over all 256
// bins empties the histogram; the same pass runs after reset. No pixel is taken
// from the last pixel of a frame until that pass ends.
module otsu_threshold_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [otsu_pkg::LVL_W-1:0] req_pixel,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [otsu_pkg::LVL_W-1:0] rsp_threshold
);
   import otsu_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_INC, ST_SCAN_RD, ST_SCAN_AC, ST_DECIDE,
      ST_SW_RD, ST_SW_AC, ST_DEN, ST_MUL_GO, ST_MUL_WAIT, ST_DONE
   } state_type;

   typedef enum logic [2:0] {MS_A, MS_B, MS_D, MS_L, MS_R} step_type;

   state_type         state_ff;
   step_type          step_ff;
   logic [LVL_W-1:0]  cnt_ff, pix_ff, lo_ff, hi_ff, best_ff, res_ff;
   logic              last_ff, found_ff, have_ff;
   logic [BIN_BITS-1:0] rdata_ff;
   logic [TOT_W-1:0]  total_ff, nb_ff;
   logic [SUM_W-1:0]  sum_ff, sb_ff;
   logic [DEN_W-1:0]  den_ff, best_den_ff;
   logic [D_W-1:0]    pa_ff, d_ff;
   logic [NUM_W-1:0]  num_ff, best_num_ff;
   logic [CROSS_W-1:0] lhs_ff;
   logic              rsp_valid_ff;
   logic [LVL_W-1:0]  rsp_threshold_ff;

   logic [BIN_BITS-1:0] mem [LEVELS];
   logic                we_c;
   logic [LVL_W-1:0]    wa_c, ra_c;
   logic [BIN_BITS-1:0] wd_c;
   logic [TOT_W-1:0]    binj_c;
   logic [MA_W-1:0]     op_a_c;
   logic [MB_W-1:0]     op_b_c;
   logic [MP_W-1:0]     product;
   logic [D_W-1:0]      pb_c;
   logic [CROSS_W-1:0]  rhs_c;
   mul_stat_type        mstat;

   otsu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_MUL_GO),
      .op_a    (op_a_c),
      .op_b    (op_b_c),
      .stat    (mstat),
      .product (product)
   );

   always_comb begin
      we_c = 1'b0;
      wa_c = cnt_ff;
      wd_c = '0;
      if (state_ff == ST_CLEAR) begin
         we_c = 1'b1;
      end else if (state_ff == ST_INC) begin
         we_c = 1'b1;
         wa_c = pix_ff;
         wd_c = (rdata_ff == BIN_MAX) ? rdata_ff : rdata_ff + 1'b1;
      end
   end

   assign ra_c   = (state_ff == ST_IDLE) ? req_pixel : cnt_ff;
   assign binj_c = TOT_W'(rdata_ff) * TOT_W'(cnt_ff);
   assign pb_c   = D_W'(product);
   assign rhs_c  = CROSS_W'(product);

   always_ff @(posedge clock) begin
      if (we_c) begin
         mem[wa_c] <= wd_c;
      end
      rdata_ff <= mem[ra_c];
   end

   always_comb begin
      unique case (step_ff)
         MS_A: begin
            op_a_c = MA_W'(sum_ff);
            op_b_c = MB_W'(nb_ff);
         end
         MS_B: begin
            op_a_c = MA_W'(sb_ff);
            op_b_c = MB_W'(total_ff);
         end
         MS_D: begin
            op_a_c = MA_W'(d_ff);
            op_b_c = d_ff;
         end
         MS_L: begin
            op_a_c = num_ff;
            op_b_c = MB_W'(best_den_ff);
         end
         MS_R: begin
            op_a_c = best_num_ff;
            op_b_c = MB_W'(den_ff);
         end
         default: begin
            op_a_c = '0;
            op_b_c = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= MS_A;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == TOP_LEVEL) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  pix_ff   <= req_pixel;
                  last_ff  <= req_last;
                  state_ff <= ST_INC;
               end
            end
            ST_INC: begin
               cnt_ff   <= '0;
               found_ff <= 1'b0;
               total_ff <= '0;
               sum_ff   <= '0;
               state_ff <= last_ff ? ST_SCAN_RD : ST_IDLE;
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_AC;
            ST_SCAN_AC: begin
               if (rdata_ff != '0) begin
                  if (!found_ff) begin
                     lo_ff <= cnt_ff;
                  end
                  found_ff <= 1'b1;
                  hi_ff    <= cnt_ff;
               end
               total_ff <= total_ff + TOT_W'(rdata_ff);
               sum_ff   <= sum_ff + SUM_W'(binj_c);
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == TOP_LEVEL) ? ST_DECIDE : ST_SCAN_RD;
            end
            ST_DECIDE: begin
               if ((hi_ff - lo_ff) <= LVL_W'(1)) begin
                  res_ff   <= lo_ff;
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff      <= lo_ff;
                  nb_ff       <= '0;
                  sb_ff       <= '0;
                  have_ff     <= 1'b0;
                  best_num_ff <= '0;
                  best_den_ff <= DEN_W'(1);
                  best_ff     <= lo_ff;
                  state_ff    <= ST_SW_RD;
               end
            end
            ST_SW_RD: state_ff <= ST_SW_AC;
            ST_SW_AC: begin
               nb_ff    <= nb_ff + TOT_W'(rdata_ff);
               sb_ff    <= sb_ff + SUM_W'(binj_c);
               state_ff <= ST_DEN;
            end
            ST_DEN: begin
               den_ff   <= DEN_W'(nb_ff) * DEN_W'(total_ff - nb_ff);
               step_ff  <= MS_A;
               state_ff <= ST_MUL_GO;
            end
            ST_MUL_GO: state_ff <= ST_MUL_WAIT;
            ST_MUL_WAIT: begin
               if (mstat.done) begin
                  state_ff <= ST_MUL_GO;
                  unique case (step_ff)
                     MS_A: begin
                        pa_ff   <= pb_c;
                        step_ff <= MS_B;
                     end
                     MS_B: begin
                        d_ff    <= (pa_ff >= pb_c) ? pa_ff - pb_c : pb_c - pa_ff;
                        step_ff <= MS_D;
                     end
                     MS_D: begin
                        num_ff  <= NUM_W'(product);
                        step_ff <= MS_L;
                     end
                     MS_L: begin
                        lhs_ff  <= rhs_c;
                        step_ff <= MS_R;
                     end
                     MS_R: begin
                        if (!have_ff || lhs_ff > rhs_c) begin
                           best_num_ff <= num_ff;
                           best_den_ff <= den_ff;
                           best_ff     <= cnt_ff;
                           have_ff     <= 1'b1;
                        end
                        if (cnt_ff + 1'b1 == hi_ff) begin
                           res_ff   <= (!have_ff || lhs_ff > rhs_c) ? cnt_ff : best_ff;
                           state_ff <= ST_DONE;
                        end else begin
                           cnt_ff   <= cnt_ff + 1'b1;
                           state_ff <= ST_SW_RD;
                        end
                     end
                     default: state_ff <= ST_MUL_GO;
                  endcase
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_threshold_ff <= res_ff;
                  rsp_valid_ff     <= 1'b1;
                  cnt_ff           <= '0;
                  state_ff         <= ST_CLEAR;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;

endmodule

### design/otsu_chk.sv
// ----------------------------------------------------------------------------
// Otsu threshold checker
// Port-level assertions on the Otsu threshold core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otsu_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [otsu_pkg::LVL_W-1:0] req_pixel,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [otsu_pkg::LVL_W-1:0] rsp_threshold
);
   import otsu_pkg::*;

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   `CHK_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_threshold), "rsp changed")
   `CHK_ASSERT(a_busy_after_req, clock, reset, req_valid && !req_stall |=> req_stall, "no busy")
   `CHK_ASSERT(a_no_rsp_midframe, clock, reset, req_valid && !req_stall && !req_last && !rsp_valid |=> !rsp_valid, "early rsp")
   `CHK_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> req_stall && !rsp_valid, "no clear pass")

endmodule

bind otsu_threshold_core otsu_chk u_otsu_chk (.*);

### test/testbench.sv
// ----------------------------------------------------------------------------
// Otsu threshold core testbench
// Streams pixel frames into the core under random idling on both sides, checks
// every threshold against a typed value or an exact integer Otsu calculation
// kept in step with the accepted pixels. Directed table first (single-level,
// adjacent-level, extreme-level and saturated-bin frames), then random frames.
// ----------------------------------------------------------------------------
module testbench;
   import otsu_pkg::*;

   typedef struct {
      logic [LVL_W-1:0] pixel;
      logic             last;
      int               count;
      bit               typed;
      logic [LVL_W-1:0] threshold;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [LVL_W-1:0] req_pixel;
   logic             req_last;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [LVL_W-1:0] rsp_threshold;

   logic [BIN_BITS-1:0] hist_bins [LEVELS];
   logic [LVL_W-1:0]    thresholds_due [$];
   int  errors = 0;
   int  pixels_sent = 0;
   int  frames_sent = 0;
   int  thresholds_seen = 0;
   bit  no_gaps = 0;
   bit  long_holdoff = 0;

   otsu_threshold_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel(req_pixel), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_threshold(rsp_threshold)
   );

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   function automatic logic [LVL_W-1:0] otsu_level();
      int lo, hi, j, best;
      bit [63:0] n_tot, s_tot, nb, sb;
      bit [255:0] a, b, d, num, den, best_num, best_den;
      lo = 0;
      while (lo < LEVELS - 1 && hist_bins[lo] == 0) lo++;
      hi = LEVELS - 1;
      while (hi > lo && hist_bins[hi] == 0) hi--;
      if (hi == lo || lo + 1 == hi) return lo[LVL_W-1:0];
      n_tot = 0; s_tot = 0;
      for (j = lo; j <= hi; j++) begin
         n_tot += hist_bins[j];
         s_tot += 64'(hist_bins[j]) * j;
      end
      nb = 0; sb = 0; best = lo;
      best_num = 0; best_den = 1;
      for (j = lo; j < hi; j++) begin
         nb += hist_bins[j];
         sb += 64'(hist_bins[j]) * j;
         a = 256'(s_tot) * 256'(nb);
         b = 256'(sb) * 256'(n_tot);
         d = (a >= b) ? a - b : b - a;
         num = d * d;
         den = 256'(nb * (n_tot - nb));
         if (j == lo || num * best_den > best_num * den) begin
            best_num = num; best_den = den; best = j;
         end
      end
      return best[LVL_W-1:0];
   endfunction

   // histogram update for one accepted pixel; queues the threshold on last
   task automatic count_pixel(input logic [LVL_W-1:0] pix, input logic last,
                              input bit typed, input logic [LVL_W-1:0] typed_thr);
      if (hist_bins[pix] != BIN_MAX) hist_bins[pix]++;
      pixels_sent++;
      if (last) begin
         thresholds_due.push_back(typed ? typed_thr : otsu_level());
         foreach (hist_bins[i]) hist_bins[i] = '0;
         frames_sent++;
      end
   endtask

   task automatic send_pixel(input logic [LVL_W-1:0] pix, input logic last,
                             input bit typed = 0, input logic [LVL_W-1:0] typed_thr = '0);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (gap) @(negedge clock);
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_last  <= last;
      do @(posedge clock); while (req_stall);
      count_pixel(pix, last, typed, typed_thr);
      @(negedge clock) req_valid <= 1'b0;
   endtask

   // result side: random stall before each transaction, one long hold-off on request
   initial begin
      int k;
      rsp_stall = 1'b1;
      @(negedge clock iff !reset);
      forever begin
         if (long_holdoff) begin
            k = 400;
            long_holdoff = 0;
         end else begin
            k = no_gaps ? 0 : $urandom_range(0, 8);
         end
         repeat (k) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         thresholds_seen++;
         if (thresholds_due.size() == 0) begin
            $display("%0t: threshold %0d with none expected", $time, rsp_threshold);
            errors++;
         end else begin
            if (rsp_threshold !== thresholds_due[0]) begin
               $display("%0t: threshold expected %0d actual %0d",
                        $time, thresholds_due[0], rsp_threshold);
               errors++;
            end
            void'(thresholds_due.pop_front());
         end
      end
   end

   initial begin
      #(12 * 20000000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      stim_row_type rows [$];
      int n, len, base, width, frame;
      bit wide;
      logic [LVL_W-1:0] pix;

      foreach (hist_bins[i]) hist_bins[i] = '0;
      reset = 1'b1; req_valid = 1'b0; req_pixel = '0; req_last = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      rows = '{
         '{8'd0,   1'b1, 1,     1, 8'd0},
         '{8'd255, 1'b1, 1,     1, 8'd255},
         '{8'd7,   1'b0, 3,     0, 8'd0},
         '{8'd7,   1'b1, 1,     1, 8'd7},
         '{8'd100, 1'b0, 1,     0, 8'd0},
         '{8'd101, 1'b1, 1,     1, 8'd100},
         '{8'd0,   1'b0, 1,     0, 8'd0},
         '{8'd255, 1'b1, 1,     1, 8'd0},
         '{8'd170, 1'b0, 2,     0, 8'd0},
         '{8'd85,  1'b0, 2,     0, 8'd0},
         '{8'd255, 1'b0, 1,     0, 8'd0},
         '{8'd0,   1'b1, 1,     0, 8'd0},
         '{8'd10,  1'b0, 65540, 0, 8'd0},
         '{8'd200, 1'b0, 3,     0, 8'd0},
         '{8'd128, 1'b1, 1,     0, 8'd0}
      };
      foreach (rows[i]) begin
         no_gaps = rows[i].count > 100;
         for (n = 0; n < rows[i].count; n++)
            send_pixel(rows[i].pixel, rows[i].last, rows[i].typed, rows[i].threshold);
      end
      no_gaps = 0;

      frame = 0;
      while (pixels_sent < 65560 + 600) begin
         wide  = ($urandom_range(0, 7) == 0);
         width = wide ? 255 : $urandom_range(0, 15);
         base  = $urandom_range(0, 255 - width);
         len   = $urandom_range(1, 40);
         no_gaps = (frame % 10 >= 7);
         if (frame == 3) long_holdoff = 1;
         for (n = 0; n < len; n++) begin
            pix = 8'(base + $urandom_range(0, width));
            send_pixel(pix, n == len - 1);
         end
         if (frame % 6 == 5) wait (thresholds_due.size() == 0);
         frame++;
      end
      no_gaps = 0;

      wait (thresholds_due.size() == 0);
      repeat (300) @(posedge clock);
      if (thresholds_due.size() != 0) begin
         $display("%0t: %0d thresholds never arrived", $time, thresholds_due.size());
         errors++;
      end
      $display("Sent %0d pixels in %0d frames, checked %0d thresholds, %0d mismatches",
               pixels_sent, frames_sent, thresholds_seen, errors);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
